### hdl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro places one labelled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, not evaluated while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, not evaluated while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dnsap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer parser package
// Shared constants, result codes, parse phases and the result structure.
// ----------------------------------------------------------------------------
package dnsap_pkg;

  // Bytes at positions MAX_DATAGRAM and beyond are not parsed.
  localparam int MAX_DATAGRAM = 512;
  // The position counter must be able to hold MAX_DATAGRAM itself.
  localparam int POS_W = $clog2(MAX_DATAGRAM + 1);

  localparam int HDR_LEN    = 12;
  localparam int OFS_RCODE  = 3;
  localparam int OFS_QDCNT  = 4;
  localparam int OFS_ANCNT  = 6;
  localparam int FIXED_LEN  = 10;
  localparam int TYPE_BYTES = 2;
  localparam int RDLEN_OFS  = 8;
  localparam int ADDR_LEN   = 4;
  localparam int QTAIL_LEN  = 4;

  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [1:0]  PTR_MARK   = 2'b11;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NO_ADDR   = 3'd2,
    ST_NO_A      = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  // Parse phases, one-hot.
  typedef enum logic [11:0] {
    PH_HEADER  = 12'b0000_0000_0001,
    PH_Q_NAME  = 12'b0000_0000_0010,
    PH_Q_LABEL = 12'b0000_0000_0100,
    PH_Q_PTR   = 12'b0000_0000_1000,
    PH_Q_TAIL  = 12'b0000_0001_0000,
    PH_A_NAME  = 12'b0000_0010_0000,
    PH_A_LABEL = 12'b0000_0100_0000,
    PH_A_PTR   = 12'b0000_1000_0000,
    PH_A_FIXED = 12'b0001_0000_0000,
    PH_A_ADDR  = 12'b0010_0000_0000,
    PH_A_RDATA = 12'b0100_0000_0000,
    PH_DONE    = 12'b1000_0000_0000
  } phase_t;

  // Result of one byte step, from the parser core to the output register.
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] address;
  } res_t;

endpackage

### hdl/dnsap_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram byte channel
// Valid/ready channel carrying one datagram byte and its end mark.
// ----------------------------------------------------------------------------
interface dnsap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/dnsap_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookup result channel
// Valid/ready channel carrying the status and address of one datagram.
// ----------------------------------------------------------------------------
interface dnsap_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] address;

  modport source (output valid, output status, output address, input ready);
  modport sink   (input valid, input status, input address, output ready);
endinterface

### hdl/dnsap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer parser core
// Holds the per-datagram parse state and advances it by one byte per step,
// producing at most one result for the byte that settles the outcome.
// ----------------------------------------------------------------------------
module dnsap_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [15:0]         expected_id,
  output dnsap_pkg::res_t     res
);

  logic [dnsap_pkg::POS_W-1:0] pos_r, pos_nxt;
  dnsap_pkg::phase_t           phase_r, phase_nxt;
  logic [15:0]                 id_r, id_nxt;
  logic [3:0]                  rcode_r, rcode_nxt;
  logic [15:0]                 qleft_r, qleft_nxt;
  logic [15:0]                 aleft_r, aleft_nxt;
  logic [15:0]                 skip_r, skip_nxt;
  logic [15:0]                 rtype_r, rtype_nxt;
  logic [15:0]                 rdlen_r, rdlen_nxt;
  logic [31:0]                 addr_r, addr_nxt;

  logic [15:0] skip_inc;
  logic [15:0] skip_dec;
  logic [15:0] qleft_dec;
  logic [15:0] aleft_dec;

  assign skip_inc  = skip_r + 16'd1;
  assign skip_dec  = skip_r - 16'd1;
  assign qleft_dec = qleft_r - 16'd1;
  assign aleft_dec = aleft_r - 16'd1;

  // Next-state and result logic for one byte.
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    id_nxt    = id_r;
    rcode_nxt = rcode_r;
    qleft_nxt = qleft_r;
    aleft_nxt = aleft_r;
    skip_nxt  = skip_r;
    rtype_nxt = rtype_r;
    rdlen_nxt = rdlen_r;
    addr_nxt  = addr_r;
    res       = '0;
    res.status = dnsap_pkg::ST_FOUND;

    if (step) begin
      if (pos_r < dnsap_pkg::POS_W'(dnsap_pkg::MAX_DATAGRAM)) begin
        case (phase_r)
          dnsap_pkg::PH_HEADER: begin
            // Collect the header fields, then give the header verdict.
            if (pos_r < dnsap_pkg::POS_W'(2)) begin
              id_nxt = {id_r[7:0], data_byte};
            end else if (pos_r == dnsap_pkg::POS_W'(dnsap_pkg::OFS_RCODE)) begin
              rcode_nxt = data_byte[3:0];
            end else if (pos_r == dnsap_pkg::POS_W'(dnsap_pkg::OFS_QDCNT) ||
                         pos_r == dnsap_pkg::POS_W'(dnsap_pkg::OFS_QDCNT + 1)) begin
              qleft_nxt = {qleft_r[7:0], data_byte};
            end else if (pos_r == dnsap_pkg::POS_W'(dnsap_pkg::OFS_ANCNT) ||
                         pos_r == dnsap_pkg::POS_W'(dnsap_pkg::OFS_ANCNT + 1)) begin
              aleft_nxt = {aleft_r[7:0], data_byte};
            end
            if (pos_r == dnsap_pkg::POS_W'(dnsap_pkg::HDR_LEN - 1)) begin
              if (id_r != expected_id) begin
                res.valid  = 1'b1;
                res.status = dnsap_pkg::ST_IGNORED;
                phase_nxt  = dnsap_pkg::PH_DONE;
              end else if (rcode_r != 4'd0) begin
                res.valid  = 1'b1;
                res.status = dnsap_pkg::ST_NOT_FOUND;
                phase_nxt  = dnsap_pkg::PH_DONE;
              end else if (aleft_r == 16'd0) begin
                res.valid  = 1'b1;
                res.status = dnsap_pkg::ST_NO_ADDR;
                phase_nxt  = dnsap_pkg::PH_DONE;
              end else begin
                phase_nxt = (qleft_r == 16'd0) ? dnsap_pkg::PH_A_NAME : dnsap_pkg::PH_Q_NAME;
              end
            end
          end
          dnsap_pkg::PH_Q_NAME: begin
            if (data_byte == 8'd0) begin
              skip_nxt  = 16'(dnsap_pkg::QTAIL_LEN);
              phase_nxt = dnsap_pkg::PH_Q_TAIL;
            end else if (data_byte[7:6] == dnsap_pkg::PTR_MARK) begin
              phase_nxt = dnsap_pkg::PH_Q_PTR;
            end else begin
              skip_nxt  = {8'd0, data_byte};
              phase_nxt = dnsap_pkg::PH_Q_LABEL;
            end
          end
          dnsap_pkg::PH_Q_LABEL: begin
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_nxt = dnsap_pkg::PH_Q_NAME;
            end
          end
          dnsap_pkg::PH_Q_PTR: begin
            skip_nxt  = 16'(dnsap_pkg::QTAIL_LEN);
            phase_nxt = dnsap_pkg::PH_Q_TAIL;
          end
          dnsap_pkg::PH_Q_TAIL: begin
            // Type and class of a question, then the next question or the answers.
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              qleft_nxt = qleft_dec;
              phase_nxt = (qleft_dec == 16'd0) ? dnsap_pkg::PH_A_NAME : dnsap_pkg::PH_Q_NAME;
            end
          end
          dnsap_pkg::PH_A_NAME: begin
            if (data_byte == 8'd0) begin
              skip_nxt  = 16'd0;
              phase_nxt = dnsap_pkg::PH_A_FIXED;
            end else if (data_byte[7:6] == dnsap_pkg::PTR_MARK) begin
              phase_nxt = dnsap_pkg::PH_A_PTR;
            end else begin
              skip_nxt  = {8'd0, data_byte};
              phase_nxt = dnsap_pkg::PH_A_LABEL;
            end
          end
          dnsap_pkg::PH_A_LABEL: begin
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_nxt = dnsap_pkg::PH_A_NAME;
            end
          end
          dnsap_pkg::PH_A_PTR: begin
            skip_nxt  = 16'd0;
            phase_nxt = dnsap_pkg::PH_A_FIXED;
          end
          dnsap_pkg::PH_A_FIXED: begin
            // Ten fixed bytes: type first, rdata length last.
            if (skip_r < 16'(dnsap_pkg::TYPE_BYTES)) begin
              rtype_nxt = {rtype_r[7:0], data_byte};
            end else if (skip_r >= 16'(dnsap_pkg::RDLEN_OFS)) begin
              rdlen_nxt = {rdlen_r[7:0], data_byte};
            end
            skip_nxt = skip_inc;
            if (skip_inc >= 16'(dnsap_pkg::FIXED_LEN)) begin
              if (rtype_nxt == dnsap_pkg::TYPE_A &&
                  rdlen_nxt == 16'(dnsap_pkg::ADDR_LEN)) begin
                skip_nxt  = 16'd0;
                addr_nxt  = 32'd0;
                phase_nxt = dnsap_pkg::PH_A_ADDR;
              end else if (rdlen_nxt == 16'd0) begin
                // Record with empty rdata ends here.
                aleft_nxt = aleft_dec;
                if (aleft_dec == 16'd0) begin
                  res.valid  = 1'b1;
                  res.status = dnsap_pkg::ST_NO_A;
                  phase_nxt  = dnsap_pkg::PH_DONE;
                end else begin
                  phase_nxt = dnsap_pkg::PH_A_NAME;
                end
              end else begin
                skip_nxt  = rdlen_nxt;
                phase_nxt = dnsap_pkg::PH_A_RDATA;
              end
            end
          end
          dnsap_pkg::PH_A_ADDR: begin
            addr_nxt = {addr_r[23:0], data_byte};
            skip_nxt = skip_inc;
            if (skip_inc >= 16'(dnsap_pkg::ADDR_LEN)) begin
              res.valid   = 1'b1;
              res.status  = dnsap_pkg::ST_FOUND;
              res.address = addr_nxt;
              phase_nxt   = dnsap_pkg::PH_DONE;
            end
          end
          dnsap_pkg::PH_A_RDATA: begin
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              aleft_nxt = aleft_dec;
              if (aleft_dec == 16'd0) begin
                res.valid  = 1'b1;
                res.status = dnsap_pkg::ST_NO_A;
                phase_nxt  = dnsap_pkg::PH_DONE;
              end else begin
                phase_nxt = dnsap_pkg::PH_A_NAME;
              end
            end
          end
          default: begin
            // Outcome already given: the byte is only counted.
          end
        endcase
        pos_nxt = pos_r + dnsap_pkg::POS_W'(1);
      end

      // End of datagram: give the fallback verdict if none was given, then clear.
      if (last_byte) begin
        if (phase_nxt != dnsap_pkg::PH_DONE) begin
          res.valid   = 1'b1;
          res.address = 32'd0;
          res.status  = (pos_nxt < dnsap_pkg::POS_W'(dnsap_pkg::HDR_LEN)) ?
                        dnsap_pkg::ST_IGNORED : dnsap_pkg::ST_NO_A;
        end
        pos_nxt   = '0;
        phase_nxt = dnsap_pkg::PH_HEADER;
        id_nxt    = '0;
        rcode_nxt = '0;
        qleft_nxt = '0;
        aleft_nxt = '0;
        skip_nxt  = '0;
        rtype_nxt = '0;
        rdlen_nxt = '0;
        addr_nxt  = '0;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= dnsap_pkg::PH_HEADER;
      id_r    <= '0;
      rcode_r <= '0;
      qleft_r <= '0;
      aleft_r <= '0;
      skip_r  <= '0;
      rtype_r <= '0;
      rdlen_r <= '0;
      addr_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      rcode_r <= rcode_nxt;
      qleft_r <= qleft_nxt;
      aleft_r <= aleft_nxt;
      skip_r  <= skip_nxt;
      rtype_r <= rtype_nxt;
      rdlen_r <= rdlen_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

### hdl/dns_answer_a_record_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer A-record parser, top level
// Parses one DNS response per datagram, byte by byte, and gives one lookup
// result per datagram: the first IPv4 address found, or the reason for none.
//
//   Channel   Direction  Payload                         Transfer
//   in_chan   sink       data_byte[7:0], last_byte       one byte per request
//   out_chan  source     status[2:0], address[31:0]      one result per datagram
//   cfg_*     write      cfg_wdata[15:0] = expected id   cfg_we, no handshake
//
// One byte is taken per cycle while no stalled result holds the parser; each
// byte passes the input register, the parser logic and the result register,
// which is loaded when the parser advances on the settling byte. Reset
// (rst_n low, synchronous) clears the parse state, the valid flags of both
// registers and the expected id. A stalled result holds the parser at the
// byte behind it; the input register takes one more byte.
// ----------------------------------------------------------------------------
module dns_answer_a_record_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  dnsap_in_if.sink           in_chan,
  dnsap_out_if.source        out_chan,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  logic            in_vld_r;
  logic [7:0]      in_byte_r;
  logic            in_last_r;
  logic [15:0]     cfg_id_r;
  logic            out_vld_r;
  logic [2:0]      out_status_r;
  logic [31:0]     out_addr_r;
  logic            adv;
  dnsap_pkg::res_t res;

  // The parser advances when a byte is held and the result slot is free.
  assign adv           = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = rst_n && (!in_vld_r || adv);

  // Expected transaction id register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_id_r <= '0;
    end else if (cfg_we) begin
      cfg_id_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.data_byte;
      in_last_r <= in_chan.last_byte;
    end
  end

  dnsap_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .data_byte   (in_byte_r),
    .last_byte   (in_last_r),
    .expected_id (cfg_id_r),
    .res         (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res.valid;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_status_r <= res.status;
      out_addr_r   <= res.address;
    end
  end

  assign out_chan.valid   = out_vld_r;
  assign out_chan.status  = out_status_r;
  assign out_chan.address = out_addr_r;

endmodule

### hdl/dnsap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer parser port checker
// Watches the top-level ports for result code, address and handshake rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dnsap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_address
);

  logic        status_ok;
  logic        addr_zero;
  logic        fail_shown;
  logic        out_stall;
  logic [34:0] out_payload;

  // Helper terms that keep the assertions short.
  assign status_ok   = (out_status <= dnsap_pkg::ST_IGNORED);
  assign addr_zero   = (out_address == 32'd0);
  assign fail_shown  = out_valid && (out_status != dnsap_pkg::ST_FOUND);
  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_status, out_address};

  // Only the five defined status codes may be shown.
  `ASSERT_IMP(a_status_range, clk, rst_n, out_valid, status_ok, "status code out of range")

  // Every outcome other than a found address carries a zero address.
  `ASSERT_IMP(a_addr_zero, clk, rst_n, fail_shown, addr_zero, "address set on a failed lookup")

  // A result that is not taken stays, unchanged.
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_payload), "stall broken")

  // Reset leaves no result pending.
  `ASSERT_NXT_ALWAYS(a_rst_clear, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind dns_answer_a_record_parser_top dnsap_checker u_dnsap_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_status  (out_chan.status),
  .out_address (out_chan.address)
);

### tb/sv/dns_answer_a_record_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer A-record parser testbench
// Drives whole response datagrams byte by byte into the parser and checks
// each lookup result against a behavioural tracker of the parse. A few short
// hand-made datagrams come first. Then come phases of mostly well-formed
// responses with random content, header rejections, truncations and noise.
// One oversized datagram is included. The expected id is rewritten between
// phases. Both channels stall in random bursts, except in the hand-made part,
// in the third phase and in the final phase.
// ----------------------------------------------------------------------------
module dns_answer_a_record_parser_top_tb;

  localparam int ITEMS       = 1850;
  localparam int PHASES      = 6;
  localparam int PHASE_BYTES = 310;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    dnsap_pkg::status_t status;
    logic [31:0]        address;
  } lookup_t;

  typedef enum {REC_ADDR, REC_BAD_LEN, REC_OTHER} rec_kind_t;

  // Follows the parse of every accepted byte and keeps the lookups still owed.
  class answer_tracker;
    logic [15:0]       query_id;
    int unsigned       position;
    dnsap_pkg::phase_t phase;
    logic [15:0]       id_seen;
    logic [3:0]        rcode;
    logic [15:0]       questions_left;
    logic [15:0]       answers_left;
    logic [15:0]       count;
    logic [15:0]       rtype;
    logic [15:0]       rdlen;
    logic [31:0]       addr_acc;
    bit                settled;
    lookup_t           awaited_lookups[$];
    int unsigned       bytes_taken;
    int unsigned       errors;

    function new();
      query_id    = '0;
      bytes_taken = 0;
      errors      = 0;
      restart();
    endfunction

    function void restart();
      position       = 0;
      phase          = dnsap_pkg::PH_HEADER;
      id_seen        = '0;
      rcode          = '0;
      questions_left = '0;
      answers_left   = '0;
      count          = '0;
      rtype          = '0;
      rdlen          = '0;
      addr_acc       = '0;
      settled        = 1'b0;
    endfunction

    function void set_query_id(logic [15:0] v);
      query_id = v;
    endfunction

    function void settle(dnsap_pkg::status_t st, logic [31:0] a);
      lookup_t l;
      l.status  = st;
      l.address = a;
      awaited_lookups.push_back(l);
      settled = 1'b1;
      phase   = dnsap_pkg::PH_DONE;
    endfunction

    // One byte of a name: end of name, compression pointer or label length.
    function dnsap_pkg::phase_t name_step(logic [7:0] b,
                                          dnsap_pkg::phase_t label_ph,
                                          dnsap_pkg::phase_t ptr_ph,
                                          dnsap_pkg::phase_t end_ph);
      if (b == 8'h00) begin
        count = (end_ph == dnsap_pkg::PH_Q_TAIL) ? 16'(dnsap_pkg::QTAIL_LEN) : 16'h0000;
        return end_ph;
      end
      if (b[7:6] == dnsap_pkg::PTR_MARK) return ptr_ph;
      count = {8'h00, b};
      return label_ph;
    endfunction

    // An answer record without a usable address has been passed over.
    function void record_end();
      answers_left = answers_left - 16'd1;
      if (answers_left == 16'd0) settle(dnsap_pkg::ST_NO_A, '0);
      else phase = dnsap_pkg::PH_A_NAME;
    endfunction

    function void parse(logic [7:0] b);
      case (phase)
        dnsap_pkg::PH_HEADER: begin
          if (position < 2) id_seen = {id_seen[7:0], b};
          else if (position == dnsap_pkg::OFS_RCODE) rcode = b[3:0];
          else if (position == dnsap_pkg::OFS_QDCNT || position == dnsap_pkg::OFS_QDCNT + 1)
            questions_left = {questions_left[7:0], b};
          else if (position == dnsap_pkg::OFS_ANCNT || position == dnsap_pkg::OFS_ANCNT + 1)
            answers_left = {answers_left[7:0], b};
          // The header verdict falls on its last byte.
          if (position == dnsap_pkg::HDR_LEN - 1) begin
            if (id_seen != query_id) settle(dnsap_pkg::ST_IGNORED, '0);
            else if (rcode != 4'h0) settle(dnsap_pkg::ST_NOT_FOUND, '0);
            else if (answers_left == 16'd0) settle(dnsap_pkg::ST_NO_ADDR, '0);
            else phase = (questions_left == 16'd0) ? dnsap_pkg::PH_A_NAME
                                                   : dnsap_pkg::PH_Q_NAME;
          end
        end
        dnsap_pkg::PH_Q_NAME:
          phase = name_step(b, dnsap_pkg::PH_Q_LABEL, dnsap_pkg::PH_Q_PTR,
                            dnsap_pkg::PH_Q_TAIL);
        dnsap_pkg::PH_Q_LABEL: begin
          count = count - 16'd1;
          if (count == 16'd0) phase = dnsap_pkg::PH_Q_NAME;
        end
        dnsap_pkg::PH_Q_PTR: begin
          count = 16'(dnsap_pkg::QTAIL_LEN);
          phase = dnsap_pkg::PH_Q_TAIL;
        end
        dnsap_pkg::PH_Q_TAIL: begin
          count = count - 16'd1;
          if (count == 16'd0) begin
            questions_left = questions_left - 16'd1;
            phase = (questions_left == 16'd0) ? dnsap_pkg::PH_A_NAME : dnsap_pkg::PH_Q_NAME;
          end
        end
        dnsap_pkg::PH_A_NAME:
          phase = name_step(b, dnsap_pkg::PH_A_LABEL, dnsap_pkg::PH_A_PTR,
                            dnsap_pkg::PH_A_FIXED);
        dnsap_pkg::PH_A_LABEL: begin
          count = count - 16'd1;
          if (count == 16'd0) phase = dnsap_pkg::PH_A_NAME;
        end
        dnsap_pkg::PH_A_PTR: begin
          count = 16'd0;
          phase = dnsap_pkg::PH_A_FIXED;
        end
        dnsap_pkg::PH_A_FIXED: begin
          if (count < dnsap_pkg::TYPE_BYTES) rtype = {rtype[7:0], b};
          else if (count >= dnsap_pkg::RDLEN_OFS) rdlen = {rdlen[7:0], b};
          count = count + 16'd1;
          if (count >= dnsap_pkg::FIXED_LEN) begin
            if (rtype == dnsap_pkg::TYPE_A && rdlen == dnsap_pkg::ADDR_LEN) begin
              count    = 16'd0;
              addr_acc = '0;
              phase    = dnsap_pkg::PH_A_ADDR;
            end else if (rdlen == 16'd0) begin
              record_end();
            end else begin
              count = rdlen;
              phase = dnsap_pkg::PH_A_RDATA;
            end
          end
        end
        dnsap_pkg::PH_A_ADDR: begin
          addr_acc = {addr_acc[23:0], b};
          count    = count + 16'd1;
          if (count >= dnsap_pkg::ADDR_LEN) settle(dnsap_pkg::ST_FOUND, addr_acc);
        end
        dnsap_pkg::PH_A_RDATA: begin
          count = count - 16'd1;
          if (count == 16'd0) record_end();
        end
        default: ;
      endcase
    endfunction

    // Notes one accepted byte request and predicts any lookup it settles.
    function void take_byte(logic [7:0] b, logic last);
      if (position < dnsap_pkg::MAX_DATAGRAM) begin
        if (!settled) parse(b);
        position++;
      end
      bytes_taken++;
      if (last) begin
        if (!settled)
          settle((position < dnsap_pkg::HDR_LEN) ? dnsap_pkg::ST_IGNORED
                                                 : dnsap_pkg::ST_NO_A, '0);
        restart();
      end
    endfunction

    // Compares one accepted result with the oldest lookup owed.
    function void check_lookup(logic [2:0] st, logic [31:0] a);
      lookup_t want;
      if (awaited_lookups.size() == 0) begin
        errors++;
        $error("unexpected lookup result: status %0d address %08h", st, a);
        return;
      end
      want = awaited_lookups.pop_front();
      if (st !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, st);
      end
      if (a !== want.address) begin
        errors++;
        $error("address: expected %08h, got %08h", want.address, a);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        req_valid = 1'b0;
  logic [7:0]  req_data  = 8'h00;
  logic        req_last  = 1'b0;
  logic        take_ready = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  int unsigned   idle_pct   = 0;
  int unsigned   stall_left = 0;
  int unsigned   quiet_cycles = 0;
  logic [7:0]    datagram[$];
  answer_tracker tracker = new();

  dnsap_in_if  in_chan();
  dnsap_out_if out_chan();

  assign in_chan.valid     = req_valid;
  assign in_chan.data_byte = req_data;
  assign in_chan.last_byte = req_last;
  assign out_chan.ready    = take_ready;

  dns_answer_a_record_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: stalls come in random bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      take_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 6);
      take_ready <= 1'b0;
    end else begin
      take_ready <= 1'b1;
    end
  end

  // Every accepted result is checked at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      tracker.check_lookup(out_chan.status, out_chan.address);
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL dns_answer_a_record_parser_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void put16(logic [15:0] v);
    datagram.push_back(v[15:8]);
    datagram.push_back(v[7:0]);
  endfunction

  function automatic void put_noise(int unsigned n);
    repeat (n) datagram.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_header(logic [15:0] id, logic [7:0] rc_byte,
                                     logic [15:0] qd, logic [15:0] an);
    put16(id);
    put_noise(1);
    datagram.push_back(rc_byte);
    put16(qd);
    put16(an);
    put_noise(4);
  endfunction

  // A name of up to three labels, ended by a zero byte or a pointer.
  function automatic void put_name();
    int unsigned n_labels;
    int unsigned len;
    int unsigned r;
    n_labels = $urandom_range(0, 3);
    repeat (n_labels) begin
      r = $urandom_range(0, 199);
      // Long labels have one of the two top bits set.
      if (r < 5) len = $urandom_range(64, 70);
      else if (r == 5) len = $urandom_range(128, 131);
      else len = $urandom_range(1, 6);
      datagram.push_back(8'(len));
      put_noise(len);
    end
    if ($urandom_range(0, 2) == 0) begin
      datagram.push_back(8'h C0 | 8'($urandom_range(0, 63)));
      put_noise(1);
    end else begin
      datagram.push_back(8'h00);
    end
  endfunction

  function automatic void put_record(rec_kind_t kind);
    logic [31:0] addr;
    int unsigned len;
    int unsigned r;
    put_name();
    case (kind)
      REC_ADDR: begin
        put16(dnsap_pkg::TYPE_A);
        put_noise(6);
        put16(16'(dnsap_pkg::ADDR_LEN));
        r = $urandom_range(0, 9);
        if (r == 0) addr = 32'h0000_0000;
        else if (r == 1) addr = 32'hFFFF_FFFF;
        else addr = $urandom;
        for (int i = 3; i >= 0; i--) datagram.push_back(addr[8*i +: 8]);
      end
      REC_BAD_LEN: begin
        put16(dnsap_pkg::TYPE_A);
        put_noise(6);
        len = $urandom_range(0, 7);
        if (len == dnsap_pkg::ADDR_LEN) len = 16;
        put16(16'(len));
        put_noise(len);
      end
      default: begin
        r = $urandom_range(0, 4);
        if (r == 0) put16(16'd5);
        else if (r == 1) put16(16'd28);
        else if (r == 2) put16(16'h0100);
        else if (r == 3) put16(16'h0101);
        else put16(16'($urandom_range(0, 65535)));
        put_noise(6);
        len = $urandom_range(0, 8);
        put16(16'(len));
        put_noise(len);
      end
    endcase
  endfunction

  function automatic rec_kind_t pick_filler();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return REC_BAD_LEN;
    return REC_OTHER;
  endfunction

  // One random response: mostly well formed, the rest rejections and noise.
  function automatic void build_response();
    int unsigned r;
    int unsigned qd;
    int unsigned n_rec;
    int unsigned an_cnt;
    int unsigned cut;
    int unsigned k;
    logic [7:0]  rb;
    logic [15:0] id;
    bit          want_addr;
    datagram.delete();
    id = tracker.query_id;
    rb = 8'($urandom_range(0, 255));
    rb[3:0] = 4'h0;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      put_noise($urandom_range(1, dnsap_pkg::HDR_LEN - 1));
    end else if (r < 14) begin
      put_header(id ^ 16'($urandom_range(1, 65535)), rb, 16'($urandom_range(0, 2)),
                 16'($urandom_range(0, 3)));
      put_noise($urandom_range(0, 6));
    end else if (r < 20) begin
      rb[3:0] = 4'($urandom_range(1, 15));
      put_header(id, rb, 16'($urandom_range(0, 2)), 16'($urandom_range(0, 3)));
      put_noise($urandom_range(0, 4));
    end else if (r < 26) begin
      put_header(id, rb, 16'($urandom_range(0, 2)), 16'h0000);
      put_noise($urandom_range(0, 4));
    end else if (r < 32) begin
      if ($urandom_range(0, 1) == 1) put16(id);
      put_noise($urandom_range(dnsap_pkg::HDR_LEN, 40) - datagram.size());
    end else begin
      qd = $urandom_range(0, 2);
      if ($urandom_range(0, 29) == 0) qd = $urandom_range(3, 65535);
      n_rec  = $urandom_range(1, 3);
      an_cnt = n_rec;
      k = $urandom_range(0, 9);
      if (k == 0) an_cnt = n_rec + $urandom_range(1, 2);
      else if (k == 1 && n_rec > 1) an_cnt = n_rec - 1;
      put_header(id, rb, 16'(qd), 16'(an_cnt));
      for (int i = 0; i < qd && i < 2; i++) begin
        put_name();
        put_noise(dnsap_pkg::QTAIL_LEN);
      end
      want_addr = ($urandom_range(0, 9) < 6);
      for (int i = 0; i < n_rec; i++) begin
        if (i == n_rec - 1 && want_addr) put_record(REC_ADDR);
        else if ($urandom_range(0, 9) == 0) put_record(REC_ADDR);
        else put_record(pick_filler());
      end
      if ($urandom_range(0, 4) == 0) put_noise($urandom_range(1, 6));
      // Truncated responses end somewhere after the header.
      if ($urandom_range(0, 6) == 0 && datagram.size() > dnsap_pkg::HDR_LEN) begin
        cut = $urandom_range(dnsap_pkg::HDR_LEN, datagram.size() - 1);
        while (datagram.size() > cut) void'(datagram.pop_back());
      end
    end
  endfunction

  // A response longer than the limit whose A record sits on the boundary.
  function automatic void build_oversize();
    int unsigned len;
    datagram.delete();
    len = ($urandom_range(0, 1) == 1) ? dnsap_pkg::MAX_DATAGRAM - 36
                                      : dnsap_pkg::MAX_DATAGRAM - 38;
    put_header(tracker.query_id, 8'h80, 16'h0000, 16'h0002);
    datagram.push_back(8'h00);
    put16(16'd5);
    put_noise(6);
    put16(16'(len));
    put_noise(len);
    datagram.push_back(8'h00);
    put16(dnsap_pkg::TYPE_A);
    put_noise(6);
    put16(16'(dnsap_pkg::ADDR_LEN));
    put_noise(dnsap_pkg::MAX_DATAGRAM + 8 - datagram.size());
  endfunction

  // Called at a falling edge; returns at the falling edge after the byte is accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    req_valid <= 1'b1;
    req_data  <= b;
    req_last  <= last;
    do @(posedge clk); while (!in_chan.ready);
    tracker.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_datagram();
    for (int i = 0; i < datagram.size(); i++) begin
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      send_byte(datagram[i], i == datagram.size() - 1);
    end
  endtask

  // Holds the sender until every owed lookup has come, then lets the
  // pipeline run empty.
  task automatic drain_lookups();
    req_valid <= 1'b0;
    while (tracker.awaited_lookups.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_expected_id(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_query_id(v);
  endtask

  initial begin
    int unsigned phase_start;
    logic [15:0] id;
    bit          more;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Hand-made datagrams against the reset id: a one-byte datagram, one
    // that stops a byte short of the header, and a failed lookup.
    datagram.delete();
    datagram.push_back(8'hFF);
    send_datagram();
    datagram.delete();
    repeat (dnsap_pkg::HDR_LEN - 1) datagram.push_back(8'h00);
    send_datagram();
    datagram.delete();
    put_header(16'h0000, 8'h85, 16'h0001, 16'h0001);
    send_datagram();

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_lookups();
      case (ph)
        0: id = 16'hFFFF;
        2: id = 16'h0000;
        default: id = 16'($urandom_range(0, 65535));
      endcase
      write_expected_id(id);
      case (ph)
        2, PHASES - 1: idle_pct = 0;
        3: idle_pct = 30;
        default: idle_pct = 15;
      endcase
      phase_start = tracker.bytes_taken;
      if (ph == 3) begin
        build_oversize();
        send_datagram();
      end
      more = 1'b1;
      while (more) begin
        build_response();
        send_datagram();
        if (ph == PHASES - 1)
          more = (tracker.bytes_taken < ITEMS);
        else
          more = (tracker.bytes_taken < phase_start + PHASE_BYTES);
      end
    end

    drain_lookups();
    repeat (4) @(negedge clk);
    if (tracker.errors == 0 && tracker.awaited_lookups.size() == 0) begin
      $display("PASS dns_answer_a_record_parser_top");
    end else begin
      $display("FAIL dns_answer_a_record_parser_top");
    end
    $finish;
  end

endmodule
